FILE: sv/rnp_pkg.sv
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types and constants of the radix number parser: request and result
// payloads, the classified character passed from front to back, parse phases.
// ----------------------------------------------------------------------------
`default_nettype none

package rnp_pkg;

    // payload widths
    localparam int CH_BITS     = 8;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 6;
    localparam int VALUE_BITS  = 32;
    localparam int OFFSET_BITS = 16;
    localparam int STATUS_BITS = 2;

    // default queue depths
    localparam int MID_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_NUMBER  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_INVALID = 2'd2;

    // radix values
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;

    // digit value of a character that is not alphanumeric
    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd36;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = 6'd10;

    // character codes
    localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CH_BITS-1:0] CH_LZ    = 8'h7a;
    localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CH_BITS-1:0] CH_UZ    = 8'h5a;
    localparam logic [CH_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CH_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_BITS-1:0] CH_HT    = 8'h09;
    localparam logic [CH_BITS-1:0] CH_CR    = 8'h0d;

    typedef struct packed {
        logic [CH_BITS-1:0] ch;
        logic               starts_string;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [OFFSET_BITS-1:0]       end_offset;
        logic [STATUS_BITS-1:0]       status;
    } out_item_t;

    // classified character, front to back
    typedef struct packed {
        logic                  start;
        logic [DIGIT_BITS-1:0] digit;
        logic                  space;
        logic                  sign;
        logic                  minus;
        logic                  zero;
        logic                  x;
    } char_class_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_FIRST,
        PH_ZERO,
        PH_ZERO_X,
        PH_DIGITS
    } phase_t;

endpackage

`default_nettype wire

FILE: sv/rnp_queue.sv
// ----------------------------------------------------------------------------
// rnp_queue
// Small first-in first-out queue of registers with push/full and pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_queue #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_data,
    output logic       full,
    input  wire logic  pop,
    output item_t      pop_data,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rnp_front.sv
// ----------------------------------------------------------------------------
// rnp_front
// Accepts character requests and classifies each character: digit value,
// whitespace, sign, zero character and hex marker.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_front (
    input  wire logic             push,
    input  wire rnp_pkg::in_item_t item,
    input  wire logic             queue_full,
    output logic                  queue_push,
    output rnp_pkg::char_class_t  cls
);

    // digit value 0..35, or none for other characters
    function automatic logic [rnp_pkg::DIGIT_BITS-1:0] digit_of(
        input logic [rnp_pkg::CH_BITS-1:0] c
    );
        logic [rnp_pkg::DIGIT_BITS-1:0] d;
        d = rnp_pkg::DIGIT_NONE;
        if (c >= rnp_pkg::CH_ZERO && c <= rnp_pkg::CH_NINE)
        begin
            d = rnp_pkg::DIGIT_BITS'(c - rnp_pkg::CH_ZERO);
        end
        else if (c >= rnp_pkg::CH_LA && c <= rnp_pkg::CH_LZ)
        begin
            d = rnp_pkg::DIGIT_BITS'(c - rnp_pkg::CH_LA) + rnp_pkg::DIGIT_TEN;
        end
        else if (c >= rnp_pkg::CH_UA && c <= rnp_pkg::CH_UZ)
        begin
            d = rnp_pkg::DIGIT_BITS'(c - rnp_pkg::CH_UA) + rnp_pkg::DIGIT_TEN;
        end
        return d;
    endfunction

    assign queue_push = push && !queue_full;

    // character classification
    always_comb
    begin
        cls.start = item.starts_string;
        cls.digit = digit_of(item.ch);
        cls.space = (item.ch == rnp_pkg::CH_SPACE)
                 || (item.ch >= rnp_pkg::CH_HT && item.ch <= rnp_pkg::CH_CR);
        cls.sign  = (item.ch == rnp_pkg::CH_PLUS) || (item.ch == rnp_pkg::CH_MINUS);
        cls.minus = (item.ch == rnp_pkg::CH_MINUS);
        cls.zero  = (item.ch == rnp_pkg::CH_ZERO);
        cls.x     = (item.ch == rnp_pkg::CH_LX) || (item.ch == rnp_pkg::CH_UX);
    end

endmodule

`default_nettype wire

FILE: sv/rnp_back.sv
// ----------------------------------------------------------------------------
// rnp_back
// Parse engine: walks the classified characters through the parse phases,
// accumulates digits with one multiply-add per character and builds results.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [rnp_pkg::RADIX_BITS-1:0]    radix_cfg,
    input  wire rnp_pkg::char_class_t              cls,
    input  wire logic                              cls_valid,
    output logic                                   cls_pop,
    input  wire logic                              res_full,
    output logic                                   res_push,
    output rnp_pkg::out_item_t                     res
);

    localparam int VB = rnp_pkg::VALUE_BITS;
    localparam int OB = rnp_pkg::OFFSET_BITS;
    localparam int RB = rnp_pkg::RADIX_BITS;

    rnp_pkg::phase_t  phase_reg, phase_next;
    logic [VB-1:0]    acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic [RB-1:0]    radix_reg, radix_next;
    logic [OB-1:0]    pos_reg, pos_next;

    logic             emit;
    logic             fire;
    logic [RB-1:0]    step_radix;
    logic [VB-1:0]    mac;
    logic [VB-1:0]    signed_acc;

    // multiply-add on the running value; a leading zero in auto mode means octal
    assign step_radix = (phase_reg == rnp_pkg::PH_ZERO && radix_reg == rnp_pkg::RADIX_AUTO)
                      ? rnp_pkg::RADIX_OCT : radix_reg;
    assign mac        = acc_reg * VB'(step_radix) + VB'(cls.digit);
    assign signed_acc = neg_reg ? (VB'(0) - acc_reg) : acc_reg;

    // parse phase and result
    always_comb
    begin
        rnp_pkg::phase_t ph;
        logic [RB-1:0]   rad;
        logic [1:0]      incs;
        logic            stop;
        logic [OB:0]     pos_sum;

        ph         = phase_reg;
        rad        = radix_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        incs       = 2'd1;
        stop       = 1'b0;
        emit       = 1'b0;
        res        = '0;
        res.status = rnp_pkg::ST_NUMBER;

        // string start restarts the parse
        if (cls.start)
        begin
            acc_next = '0;
            neg_next = 1'b0;
            pos_next = '0;
            rad      = radix_cfg;
            ph       = rnp_pkg::PH_LEAD;
            if (radix_cfg > rnp_pkg::RADIX_MAX)
            begin
                rad        = rnp_pkg::RADIX_AUTO;
                emit       = 1'b1;
                res.status = rnp_pkg::ST_INVALID;
                ph         = rnp_pkg::PH_IDLE;
                stop       = 1'b1;
            end
        end

        if (!stop)
        begin
            unique case (ph)
                rnp_pkg::PH_LEAD, rnp_pkg::PH_FIRST:
                begin
                    if (ph == rnp_pkg::PH_LEAD && cls.space)
                    begin
                        ph = rnp_pkg::PH_LEAD;
                    end
                    else if (ph == rnp_pkg::PH_LEAD && cls.sign)
                    begin
                        neg_next = cls.minus;
                        ph       = rnp_pkg::PH_FIRST;
                    end
                    else if (cls.zero
                             && (rad == rnp_pkg::RADIX_AUTO || rad == rnp_pkg::RADIX_HEX))
                    begin
                        acc_next = '0;
                        ph       = rnp_pkg::PH_ZERO;
                    end
                    else
                    begin
                        if (rad == rnp_pkg::RADIX_AUTO)
                        begin
                            rad = rnp_pkg::RADIX_DEC;
                        end
                        if (cls.digit >= rad)
                        begin
                            emit       = 1'b1;
                            res.status = rnp_pkg::ST_NONE;
                            ph         = rnp_pkg::PH_IDLE;
                        end
                        else
                        begin
                            acc_next = VB'(cls.digit);
                            ph       = rnp_pkg::PH_DIGITS;
                        end
                    end
                end
                rnp_pkg::PH_ZERO:
                begin
                    if (cls.x && (rad == rnp_pkg::RADIX_AUTO || rad == rnp_pkg::RADIX_HEX))
                    begin
                        // offset stays on the x until a hex digit confirms it
                        rad  = rnp_pkg::RADIX_HEX;
                        ph   = rnp_pkg::PH_ZERO_X;
                        incs = 2'd0;
                    end
                    else
                    begin
                        rad = step_radix;
                        ph  = rnp_pkg::PH_DIGITS;
                        if (cls.digit < rad)
                        begin
                            acc_next = mac;
                        end
                        else
                        begin
                            emit           = 1'b1;
                            res.value      = signed_acc;
                            res.end_offset = pos_reg;
                            ph             = rnp_pkg::PH_IDLE;
                        end
                    end
                end
                rnp_pkg::PH_ZERO_X:
                begin
                    if (cls.digit < rnp_pkg::RADIX_HEX)
                    begin
                        acc_next = VB'(cls.digit);
                        ph       = rnp_pkg::PH_DIGITS;
                        incs     = 2'd2;
                    end
                    else
                    begin
                        // number is the zero before the x
                        emit           = 1'b1;
                        res.end_offset = pos_reg;
                        ph             = rnp_pkg::PH_IDLE;
                    end
                end
                rnp_pkg::PH_DIGITS:
                begin
                    if (cls.digit < rad)
                    begin
                        acc_next = mac;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        res.value      = signed_acc;
                        res.end_offset = pos_reg;
                        ph             = rnp_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    ph = rnp_pkg::PH_IDLE;
                end
            endcase
        end

        // saturating offset advance
        pos_sum = {1'b0, pos_next} + (OB+1)'(incs);
        if (ph != rnp_pkg::PH_IDLE)
        begin
            pos_next = pos_sum[OB] ? {OB{1'b1}} : pos_sum[OB-1:0];
        end

        phase_next = ph;
        radix_next = rad;
    end

    // a character moves on unless its result finds the result queue full
    assign fire     = cls_valid && (!emit || !res_full);
    assign cls_pop  = fire;
    assign res_push = fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rnp_pkg::PH_IDLE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            radix_reg <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/radix_number_parser.sv
// ----------------------------------------------------------------------------
// radix_number_parser
// Streaming ASCII to integer parser in the manner of strtol.
//
// Requests: one character per push, accepted at a clock edge with push high
// and full low; starts_string marks the first character of a string. Results:
// the oldest result sits on result while empty is low and leaves on pop.
// A string gives at most one result (value, end offset, status), on the
// character that ends its number; characters outside a string are dropped.
// Configuration: cfg_radix is written when cfg_valid and cfg_ready are high
// (ready is always high) and is sampled at each string start; write it only
// while no character is in flight.
// Throughput: one character per cycle while the result queue has room. A
// result reaches the result ports through the classify queue register and
// then the result queue register; the parse engine, combinational with its
// one multiply-add per character, sits between them.
// When pop stays low the result queue fills, the parse engine holds the
// character that would produce the next result, and full rises once the
// classify queue fills behind it. Reset empties both queues, clears the
// radix register to auto-detect and puts the parser in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_number_parser #(
    parameter int MID_DEPTH = rnp_pkg::MID_DEPTH,
    parameter int RES_DEPTH = rnp_pkg::RES_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire rnp_pkg::in_item_t                item,
    output logic                                  full,
    output logic                                  empty,
    input  wire logic                             pop,
    output rnp_pkg::out_item_t                    result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rnp_pkg::RADIX_BITS-1:0]   cfg_radix
);

    logic [rnp_pkg::RADIX_BITS-1:0] radix_reg;

    rnp_pkg::char_class_t front_cls;
    rnp_pkg::char_class_t mid_cls;
    logic                 mid_push;
    logic                 mid_full;
    logic                 mid_empty;
    logic                 mid_pop;
    rnp_pkg::out_item_t   back_res;
    logic                 res_push;
    logic                 res_full;

    // radix register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rnp_pkg::RADIX_AUTO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= cfg_radix;
        end
    end

    // front: accept and classify
    rnp_front u_front (
        .push       (push),
        .item       (item),
        .queue_full (mid_full),
        .queue_push (mid_push),
        .cls        (front_cls)
    );

    assign full = mid_full;

    // queue between classify and parse
    rnp_queue #(
        .item_t (rnp_pkg::char_class_t),
        .DEPTH  (MID_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (front_cls),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_cls),
        .empty     (mid_empty)
    );

    // back: parse engine
    rnp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix_cfg (radix_reg),
        .cls       (mid_cls),
        .cls_valid (!mid_empty),
        .cls_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // result queue
    rnp_queue #(
        .item_t (rnp_pkg::out_item_t),
        .DEPTH  (RES_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (back_res),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (result),
        .empty     (empty)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming radix number parser. A short table of
// directed strings opens the run, then random strings across a series of
// radix settings and a long result-side stall that backs the block up. Every
// result is compared field by field with an in-order prediction of the parse.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int PHASES          = 15;

    // directed table rows: plain character, string start, radix write
    typedef enum logic [1:0] {
        ROW_CHAR,
        ROW_START,
        ROW_RADIX
    } row_op_t;

    typedef struct packed {
        row_op_t            op;
        logic [7:0]         data;
        logic               typed;
        rnp_pkg::out_item_t want;
    } dir_row_t;

    localparam rnp_pkg::out_item_t NO_WANT = '0;
    localparam int DIR_ROWS = 31;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // signed hex with prefix and a leading blank, right after reset
        '{ROW_START, rnp_pkg::CH_SPACE, 1'b0, NO_WANT},
        '{ROW_CHAR,  rnp_pkg::CH_MINUS, 1'b0, NO_WANT},
        '{ROW_CHAR,  rnp_pkg::CH_ZERO,  1'b0, NO_WANT},
        '{ROW_CHAR,  rnp_pkg::CH_LX,    1'b0, NO_WANT},
        '{ROW_CHAR,  8'h31,             1'b0, NO_WANT},
        '{ROW_CHAR,  8'h66,             1'b0, NO_WANT},
        '{ROW_CHAR,  8'h2c,             1'b1, '{-32'sd31, 16'd6, rnp_pkg::ST_NUMBER}},
        // hex prefix without a hex digit after it
        '{ROW_START, rnp_pkg::CH_ZERO,  1'b0, NO_WANT},
        '{ROW_CHAR,  rnp_pkg::CH_UX,    1'b0, NO_WANT},
        '{ROW_CHAR,  8'h67,             1'b1, '{32'sd0, 16'd1, rnp_pkg::ST_NUMBER}},
        // auto-detected octal
        '{ROW_START, rnp_pkg::CH_ZERO,  1'b0, NO_WANT},
        '{ROW_CHAR,  8'h31,             1'b0, NO_WANT},
        '{ROW_CHAR,  8'h37,             1'b0, NO_WANT},
        '{ROW_CHAR,  8'h38,             1'b0, NO_WANT},
        // no number, then a character while idle, then a high character
        '{ROW_START, rnp_pkg::CH_LZ,    1'b1, '{32'sd0, 16'd0, rnp_pkg::ST_NONE}},
        '{ROW_CHAR,  8'hff,             1'b0, NO_WANT},
        '{ROW_START, 8'h80,             1'b1, '{32'sd0, 16'd0, rnp_pkg::ST_NONE}},
        // top radix
        '{ROW_RADIX, {2'b00, rnp_pkg::RADIX_MAX}, 1'b0, NO_WANT},
        '{ROW_START, rnp_pkg::CH_UZ,    1'b0, NO_WANT},
        '{ROW_CHAR,  rnp_pkg::CH_LZ,    1'b0, NO_WANT},
        '{ROW_CHAR,  8'h00,             1'b0, NO_WANT},
        // invalid radix
        '{ROW_RADIX, 8'd63,             1'b0, NO_WANT},
        '{ROW_START, rnp_pkg::CH_UA,    1'b1, '{32'sd0, 16'd0, rnp_pkg::ST_INVALID}},
        // radix one
        '{ROW_RADIX, 8'd1,              1'b0, NO_WANT},
        '{ROW_START, rnp_pkg::CH_ZERO,  1'b0, NO_WANT},
        '{ROW_CHAR,  8'h31,             1'b0, NO_WANT},
        // binary, restarted in the middle of a string
        '{ROW_RADIX, 8'd2,              1'b0, NO_WANT},
        '{ROW_START, 8'h31,             1'b0, NO_WANT},
        '{ROW_START, 8'h31,             1'b0, NO_WANT},
        '{ROW_CHAR,  rnp_pkg::CH_ZERO,  1'b0, NO_WANT},
        '{ROW_CHAR,  rnp_pkg::CH_SPACE, 1'b0, NO_WANT}
    };

    localparam logic [rnp_pkg::RADIX_BITS-1:0] RADIX_PLAN [PHASES] = '{
        6'd0, 6'd10, 6'd16, 6'd2, 6'd36, 6'd37, 6'd8, 6'd1,
        6'd0, 6'd63, 6'd16, 6'd0, 6'd5, 6'd0, 6'd10
    };

    // dut signals
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    rnp_pkg::in_item_t              item = '0;
    logic                           full;
    logic                           empty;
    logic                           pop = 1'b0;
    rnp_pkg::out_item_t             result;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rnp_pkg::RADIX_BITS-1:0] cfg_radix = '0;

    // typed expectation riding along with a directed request
    logic               item_typed = 1'b0;
    rnp_pkg::out_item_t item_want = '0;

    // traffic shaping
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic pressure_on = 1'b0;
    logic hold_served = 1'b0;

    // parser state as predicted
    logic [rnp_pkg::RADIX_BITS-1:0]  radix_reg = rnp_pkg::RADIX_AUTO;
    rnp_pkg::phase_t                 ps_phase = rnp_pkg::PH_IDLE;
    logic [rnp_pkg::VALUE_BITS-1:0]  ps_acc = '0;
    logic                            ps_neg = 1'b0;
    logic [rnp_pkg::RADIX_BITS-1:0]  ps_base = '0;
    logic [rnp_pkg::OFFSET_BITS-1:0] ps_pos = '0;

    rnp_pkg::out_item_t owed_numbers[$];
    logic [rnp_pkg::RADIX_BITS-1:0] radix_now = rnp_pkg::RADIX_AUTO;

    int errors = 0;
    int chars_sent = 0;
    int results_checked = 0;
    int settings_used = 0;

    radix_number_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_radix (cfg_radix)
    );

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parse prediction
    // ------------------------------------------------------------------

    function automatic logic [rnp_pkg::DIGIT_BITS-1:0] digit_value(input logic [7:0] c);
        if (c >= rnp_pkg::CH_ZERO && c <= rnp_pkg::CH_NINE)
            return rnp_pkg::DIGIT_BITS'(c - rnp_pkg::CH_ZERO);
        if (c >= rnp_pkg::CH_LA && c <= rnp_pkg::CH_LZ)
            return rnp_pkg::DIGIT_BITS'(c - rnp_pkg::CH_LA) + rnp_pkg::DIGIT_TEN;
        if (c >= rnp_pkg::CH_UA && c <= rnp_pkg::CH_UZ)
            return rnp_pkg::DIGIT_BITS'(c - rnp_pkg::CH_UA) + rnp_pkg::DIGIT_TEN;
        return rnp_pkg::DIGIT_NONE;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == rnp_pkg::CH_SPACE) || (c >= rnp_pkg::CH_HT && c <= rnp_pkg::CH_CR);
    endfunction

    function automatic logic [rnp_pkg::OFFSET_BITS-1:0] bump(
        input logic [rnp_pkg::OFFSET_BITS-1:0] p
    );
        return (p == '1) ? p : p + 1'b1;
    endfunction

    // hand back a number and drop to idle
    function automatic rnp_pkg::out_item_t close_string(
        input logic [rnp_pkg::VALUE_BITS-1:0]  v,
        input logic [rnp_pkg::OFFSET_BITS-1:0] off,
        input logic [rnp_pkg::STATUS_BITS-1:0] st
    );
        rnp_pkg::out_item_t r;
        r.value      = v;
        r.end_offset = off;
        r.status     = st;
        ps_phase     = rnp_pkg::PH_IDLE;
        return r;
    endfunction

    // first character after blanks and sign
    function automatic logic first_digit(input logic [7:0] c,
                                         output rnp_pkg::out_item_t r);
        logic [rnp_pkg::DIGIT_BITS-1:0] d;
        r = '0;
        if (c == rnp_pkg::CH_ZERO &&
            (ps_base == rnp_pkg::RADIX_AUTO || ps_base == rnp_pkg::RADIX_HEX))
        begin
            ps_acc   = '0;
            ps_phase = rnp_pkg::PH_ZERO;
            return 1'b0;
        end
        if (ps_base == rnp_pkg::RADIX_AUTO)
            ps_base = rnp_pkg::RADIX_DEC;
        d = digit_value(c);
        if (d >= ps_base)
        begin
            r = close_string('0, '0, rnp_pkg::ST_NONE);
            return 1'b1;
        end
        ps_acc   = rnp_pkg::VALUE_BITS'(d);
        ps_phase = rnp_pkg::PH_DIGITS;
        return 1'b0;
    endfunction

    // one more digit, or the end of the number
    function automatic logic more_digit(input logic [7:0] c,
                                        output rnp_pkg::out_item_t r);
        logic [rnp_pkg::DIGIT_BITS-1:0] d;
        r = '0;
        d = digit_value(c);
        if (d < ps_base)
        begin
            ps_acc = ps_acc * rnp_pkg::VALUE_BITS'(ps_base) + rnp_pkg::VALUE_BITS'(d);
            return 1'b0;
        end
        r = close_string(ps_neg ? ('0 - ps_acc) : ps_acc, ps_pos, rnp_pkg::ST_NUMBER);
        return 1'b1;
    endfunction

    // advance the predicted parse by one character
    function automatic logic parse_char(input logic [7:0] c, input logic s,
                                        output rnp_pkg::out_item_t r);
        logic made;
        made = 1'b0;
        r    = '0;
        if (s)
        begin
            ps_acc  = '0;
            ps_neg  = 1'b0;
            ps_pos  = '0;
            ps_base = radix_reg;
            if (radix_reg > rnp_pkg::RADIX_MAX)
            begin
                ps_base = '0;
                r = close_string('0, '0, rnp_pkg::ST_INVALID);
                return 1'b1;
            end
            ps_phase = rnp_pkg::PH_LEAD;
        end
        case (ps_phase)
            rnp_pkg::PH_LEAD:
            begin
                if (is_blank(c))
                    made = 1'b0;
                else if (c == rnp_pkg::CH_MINUS || c == rnp_pkg::CH_PLUS)
                begin
                    ps_neg   = (c == rnp_pkg::CH_MINUS);
                    ps_phase = rnp_pkg::PH_FIRST;
                end
                else
                    made = first_digit(c, r);
            end
            rnp_pkg::PH_FIRST:
                made = first_digit(c, r);
            rnp_pkg::PH_ZERO:
            begin
                if ((c == rnp_pkg::CH_LX || c == rnp_pkg::CH_UX) &&
                    (ps_base == rnp_pkg::RADIX_AUTO || ps_base == rnp_pkg::RADIX_HEX))
                begin
                    // offset stays on the x
                    ps_base  = rnp_pkg::RADIX_HEX;
                    ps_phase = rnp_pkg::PH_ZERO_X;
                    return 1'b0;
                end
                if (ps_base == rnp_pkg::RADIX_AUTO)
                    ps_base = rnp_pkg::RADIX_OCT;
                ps_phase = rnp_pkg::PH_DIGITS;
                made = more_digit(c, r);
            end
            rnp_pkg::PH_ZERO_X:
            begin
                if (digit_value(c) < rnp_pkg::RADIX_HEX)
                begin
                    ps_acc   = rnp_pkg::VALUE_BITS'(digit_value(c));
                    ps_phase = rnp_pkg::PH_DIGITS;
                    ps_pos   = bump(bump(ps_pos));
                    return 1'b0;
                end
                r = close_string('0, ps_pos, rnp_pkg::ST_NUMBER);
                return 1'b1;
            end
            rnp_pkg::PH_DIGITS:
                made = more_digit(c, r);
            default:
            begin
                ps_phase = rnp_pkg::PH_IDLE;
                return 1'b0;
            end
        endcase
        if (ps_phase != rnp_pkg::PH_IDLE)
            ps_pos = bump(ps_pos);
        return made;
    endfunction

    // ------------------------------------------------------------------
    // monitor: predict on accepted requests, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rnp_pkg::out_item_t guess;
        rnp_pkg::out_item_t want;
        logic               made;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (owed_numbers.size() == 0)
                begin
                    errors++;
                    $error("unexpected result: value %0d offset %0d status %0d",
                           result.value, result.end_offset, result.status);
                end
                else
                begin
                    want = owed_numbers.pop_front();
                    results_checked++;
                    if (result.value !== want.value)
                    begin
                        errors++;
                        $error("value: expected %0d, got %0d", want.value, result.value);
                    end
                    if (result.end_offset !== want.end_offset)
                    begin
                        errors++;
                        $error("end_offset: expected %0d, got %0d",
                               want.end_offset, result.end_offset);
                    end
                    if (result.status !== want.status)
                    begin
                        errors++;
                        $error("status: expected %0d, got %0d", want.status, result.status);
                    end
                end
            end
            if (push && !full)
            begin
                made = parse_char(item.ch, item.starts_string, guess);
                if (item_typed)
                    owed_numbers.push_back(item_want);
                else if (made)
                    owed_numbers.push_back(guess);
            end
            if (cfg_valid && cfg_ready)
                radix_reg = cfg_radix;
        end
    end

    // ------------------------------------------------------------------
    // result side: random pop, with one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (pressure_on && !hold_served)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served <= 1'b1;
            end
            else
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles without any handshake
    // ------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                 STALL_LIMIT, owed_numbers.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // request side helpers, all entered and left just after a rising edge
    // ------------------------------------------------------------------

    task automatic send_char(input logic [7:0] c, input logic s, input logic typed,
                             input rnp_pkg::out_item_t want);
        logic taken;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        item       <= '{ch: c, starts_string: s};
        item_typed <= typed;
        item_want  <= want;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        chars_sent++;
    endtask

    // stop sending, let every owed result arrive, then let the pipe empty
    task automatic settle();
        push <= 1'b0;
        do
            @(negedge clk);
        while (owed_numbers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(input logic [rnp_pkg::RADIX_BITS-1:0] v);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_radix <= v;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        radix_now = v;
        settings_used++;
    endtask

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
            return rnp_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? rnp_pkg::CH_LA : rnp_pkg::CH_UA) + 8'(v - 10);
    endfunction

    // one random string: mostly well formed, some noise, some cut short
    task automatic send_random_string(output int counted);
        rnp_pkg::in_item_t s[$];
        int pick;
        int style;
        int base;
        int n;
        int v;
        int k;
        logic nonzero_first;
        pick = $urandom_range(0, 99);
        style = 2;
        nonzero_first = 1'b0;
        if (radix_now > rnp_pkg::RADIX_MAX)
        begin
            // only the string start matters, the rest is dropped
            s.push_back('{ch: 8'($urandom_range(0, 255)), starts_string: 1'b1});
            if ($urandom_range(0, 3) == 0)
                s.push_back('{ch: 8'($urandom_range(0, 255)), starts_string: 1'b0});
        end
        else if (pick < 10)
        begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
                s.push_back('{ch: 8'($urandom_range(0, 255)),
                              starts_string: ($urandom_range(0, 3) == 0)});
        end
        else
        begin
            // leading blanks and sign
            repeat ($urandom_range(0, 2))
                s.push_back('{ch: ($urandom_range(0, 5) == 5) ? rnp_pkg::CH_SPACE
                                  : rnp_pkg::CH_HT + 8'($urandom_range(0, 4)),
                              starts_string: 1'b0});
            case ($urandom_range(0, 2))
                1: s.push_back('{ch: rnp_pkg::CH_PLUS, starts_string: 1'b0});
                2: s.push_back('{ch: rnp_pkg::CH_MINUS, starts_string: 1'b0});
                default: ;
            endcase
            // prefix and effective base
            base = radix_now;
            if (radix_now == rnp_pkg::RADIX_AUTO || radix_now == rnp_pkg::RADIX_HEX)
            begin
                style = $urandom_range(0, 3);
                if (style == 0)
                begin
                    s.push_back('{ch: rnp_pkg::CH_ZERO, starts_string: 1'b0});
                    s.push_back('{ch: $urandom_range(0, 1) ? rnp_pkg::CH_LX : rnp_pkg::CH_UX,
                                  starts_string: 1'b0});
                    base = rnp_pkg::RADIX_HEX;
                end
                else if (style == 1)
                begin
                    s.push_back('{ch: rnp_pkg::CH_ZERO, starts_string: 1'b0});
                    if (radix_now == rnp_pkg::RADIX_AUTO)
                        base = rnp_pkg::RADIX_OCT;
                end
                else if (radix_now == rnp_pkg::RADIX_AUTO)
                begin
                    base = rnp_pkg::RADIX_DEC;
                    nonzero_first = 1'b1;
                end
            end
            // digits, a few long enough to wrap
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
            if (style == 0 && $urandom_range(0, 7) == 0)
                n = 0;
            for (k = 0; k < n; k++)
            begin
                v = $urandom_range(0, base - 1);
                if (k == 0 && nonzero_first && v == 0)
                    v = 1;
                s.push_back('{ch: digit_char(v), starts_string: 1'b0});
            end
            // terminator, left off now and then so the next start drops the parse
            if (pick >= 20)
            begin
                s.push_back('{ch: ($urandom_range(0, 3) == 0) ? 8'h00
                                  : 8'($urandom_range(0, 255)), starts_string: 1'b0});
                if ($urandom_range(0, 3) == 0)
                    s.push_back('{ch: 8'($urandom_range(0, 255)), starts_string: 1'b0});
            end
            s[0].starts_string = 1'b1;
        end
        counted = s.size();
        foreach (s[k])
            send_char(s[k].ch, s[k].starts_string, 1'b0, NO_WANT);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t                       row;
        int                             i;
        int                             done;
        int                             counted;
        logic [rnp_pkg::RADIX_BITS-1:0] r;

        tx_idle_pct = 17;
        rx_idle_pct <= 86;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            if (row.op == ROW_RADIX)
            begin
                settle();
                write_radix(row.data[rnp_pkg::RADIX_BITS-1:0]);
            end
            else
                send_char(row.data, row.op == ROW_START, row.typed, row.want);
        end

        // random strings over a series of radix settings
        for (i = 0; i < PHASES; i++)
        begin
            if (i == 5)
            begin
                tx_idle_pct = 86;
                rx_idle_pct <= 17;
            end
            else if (i == 10)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            r = (i == 12) ? rnp_pkg::RADIX_BITS'($urandom_range(2, rnp_pkg::RADIX_MAX))
                          : RADIX_PLAN[i];
            settle();
            write_radix(r);
            // back the block up behind a long result stall
            if (i == 10)
            begin
                pressure_on <= 1'b1;
                while (!hold_served)
                    send_random_string(counted);
                pressure_on <= 1'b0;
            end
            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                send_random_string(counted);
                done += counted;
            end
        end

        settle();
        if (owed_numbers.size() != 0)
        begin
            errors++;
            $error("%0d results never arrived", owed_numbers.size());
        end

        $display("run: %0d characters sent, %0d results checked, %0d radix writes",
                 chars_sent, results_checked, settings_used);
        $display("run: covered a long result stall that filled the block, %0d errors",
                 errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
